@@ src/ssf_pkg.sv @@
package ssf_pkg;

  localparam int VAL_W     = 16;
  localparam int SAT_LIMIT = 9999;
  localparam int NUM_W     = $clog2(SAT_LIMIT + 1);  // 14 bits hold 0..9999
  localparam int BASE_W    = 5;
  localparam int REM_W     = 4;                      // remainder < base <= 16
  localparam int SEG_W     = 7;
  localparam int DIGITS    = 4;
  localparam int DIG_CNT_W = $clog2(DIGITS);
  localparam int BIT_CNT_W = $clog2(NUM_W);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

  // Per-cycle command to every cell of the dividend chain
  typedef struct packed {
    logic load;
    logic shift;
  } ssf_cell_ctl_t;

  // Hex seven-segment patterns, bit 0 = segment a
  function automatic logic [SEG_W-1:0] seg_lut(input logic [REM_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      default: s = 7'h71;
    endcase
    return s;
  endfunction

endpackage

@@ src/ssf_cell.sv @@
// One bit of the dividend/quotient chain
module ssf_cell import ssf_pkg::*; (
  input  logic          clk,
  input  ssf_cell_ctl_t ctl,
  input  logic          load_bit,
  input  logic          shift_in,
  input  logic          any_in,
  output logic          q,
  output logic          any_out
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_bit;
    end else if (ctl.shift) begin
      q <= shift_in;
    end
  end

  // ripple OR: is any bit at or below this cell set
  assign any_out = q | any_in;

endmodule

@@ src/seven_segment_number_formatter.sv @@
// Flow: an accepted item is divided bit-serially over the 14-bit chain, digit by
//   digit, one bit per divide step, and the four digits then go to the output load.
// Items: one at a time; the next item is accepted as soon as the divider is back
//   in idle, even while the previous result still waits.
// Reset (rst, synchronous): control idle, no result pending, base back to 10.
module seven_segment_number_formatter import ssf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [BASE_W-1:0] cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VAL_W-1:0]  value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SEG_W-1:0]  seg_rightmost,
  output logic [SEG_W-1:0]  seg_second,
  output logic [SEG_W-1:0]  seg_third,
  output logic [SEG_W-1:0]  seg_leftmost
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,   // waiting for an item
    S_DIV  = 3'b010,   // shifting the chain, one quotient bit per cycle
    S_HOLD = 3'b100    // digits done, waiting for the output register
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [BASE_W-1:0]      base_reg;
  logic [BASE_W-1:0]      base_eff;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_cur;
  logic [BASE_W-1:0]      trial;
  logic [BASE_W-1:0]      rem_next;
  logic                   qbit;
  logic                   shown;
  logic                   shown_cur;
  logic [SEG_W-1:0]       dig [DIGITS];
  logic [NUM_W-1:0]       sat_value;
  logic [NUM_W-1:0]       chain;
  logic [NUM_W:0]         any_ch;
  ssf_cell_ctl_t          cell_ctl;
  logic                   in_acc;
  logic                   div_last;
  logic                   out_load;

  // Config register; the clamp to 2..16 is applied on the read side
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= BASE_RESET;
    end else if (cfg_write_en) begin
      base_reg <= cfg_write_data;
    end
  end

  always_comb begin
    priority if (base_reg < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (base_reg > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = base_reg;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign div_last = (state == S_DIV) && (bit_cnt == BIT_CNT_W'(NUM_W - 1));
  assign out_load = (state == S_HOLD) && (!out_valid || out_ready);

  // Values above 9999 show as 9999
  assign sat_value = (value > VAL_W'(SAT_LIMIT)) ? NUM_W'(SAT_LIMIT) : value[NUM_W-1:0];

  assign cell_ctl.load  = in_acc;
  assign cell_ctl.shift = (state == S_DIV);

  // Dividend chain: MSB leaves into the remainder unit, quotient bit enters at cell 0.
  // Once every bit of the chain has been shifted, it holds the quotient, ready for the next digit.
  assign any_ch[0] = 1'b0;

  for (genvar i = 0; i < NUM_W; i++) begin : g_chain
    logic sh_in;
    if (i == 0) begin : g_first
      assign sh_in = qbit;
    end else begin : g_rest
      assign sh_in = chain[i-1];
    end
    ssf_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .load_bit (sat_value[i]),
      .shift_in (sh_in),
      .any_in   (any_ch[i]),
      .q        (chain[i]),
      .any_out  (any_ch[i+1])
    );
  end

  // Restoring divide step; remainder restarts at zero on each digit
  assign rem_cur  = (bit_cnt == '0) ? '0 : rem;
  assign trial    = {rem_cur, chain[NUM_W-1]};
  assign qbit     = (trial >= base_eff);
  assign rem_next = qbit ? (trial - base_eff) : trial;

  // A digit is shown if its dividend was non-zero, or it is the rightmost one
  assign shown_cur = (bit_cnt == '0) ? ((dig_cnt == '0) | any_ch[NUM_W]) : shown;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = S_DIV;
      S_DIV: begin
        if (div_last && dig_cnt == DIG_CNT_W'(DIGITS - 1)) state_next = S_HOLD;
      end
      S_HOLD: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
      dig_cnt <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        bit_cnt <= '0;
        dig_cnt <= '0;
      end else if (state == S_DIV) begin
        if (div_last) begin
          bit_cnt <= '0;
          dig_cnt <= dig_cnt + 1'b1;
        end else begin
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      rem   <= rem_next[REM_W-1:0];
      shown <= shown_cur;
      if (div_last) begin
        dig[dig_cnt] <= shown_cur ? seg_lut(rem_next[REM_W-1:0]) : '0;
      end
    end
  end

  // Output register parts the result side from the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      seg_rightmost <= dig[0];
      seg_second    <= dig[1];
      seg_third     <= dig[2];
      seg_leftmost  <= dig[3];
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (!in_ready && bit_cnt == '0 && dig_cnt == '0))
    else $error("divider not started after item acceptance");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && bit_cnt != '0) |-> (BASE_W'(rem) < base_eff))
    else $error("remainder not below base");

  a_digit_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seg_rightmost != '0))
    else $error("rightmost digit blank");

  a_blank_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((seg_leftmost == '0 || seg_third != '0) &&
                   (seg_third == '0 || seg_second != '0)))
    else $error("blank digit right of a shown digit");
`endif

endmodule
